// File: design/flash_block_state_map_top_defines.svh
// Assertion macros shared by the flash block state map RTL.
// Needs a clock named clk and an active-low reset named rst_n in scope.
`ifndef FLASH_BLOCK_STATE_MAP_TOP_DEFINES_SVH
`define FLASH_BLOCK_STATE_MAP_TOP_DEFINES_SVH

// The consequence must hold in the same cycle as the antecedent.
`define FBSM_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// The consequence must hold in the cycle after the antecedent.
`define FBSM_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// File: design/fbsm_pkg.sv
// Shared types, codes and constants of the flash block state map.
// Used by every module of the block; depends on nothing.
package fbsm_pkg;

    localparam int unsigned MAP_BLOCKS_DEF = 16384;
    localparam int unsigned MAX_ERASE_SPAN = 128;

    // Field widths of the request and result ports.
    localparam int unsigned MODE_W  = 3;
    localparam int unsigned IDX_W   = 14;
    localparam int unsigned CNT_W   = 15;
    localparam int unsigned ST_W    = 2;
    localparam int unsigned SHIFT_W = 3;
    // Wide enough for start_block + block_count.
    localparam int unsigned POS_W   = 16;

    localparam logic [MODE_W-1:0] MODE_MARK   = 3'd0;
    localparam logic [MODE_W-1:0] MODE_CLEAR  = 3'd1;
    localparam logic [MODE_W-1:0] MODE_ERASE  = 3'd2;
    localparam logic [MODE_W-1:0] MODE_SEARCH = 3'd3;
    localparam logic [MODE_W-1:0] MODE_QUERY  = 3'd4;

    localparam logic [ST_W-1:0] BS_DIRTY    = 2'd0;
    localparam logic [ST_W-1:0] BS_ERASED   = 2'd1;
    localparam logic [ST_W-1:0] BS_LOCKED   = 2'd2;
    localparam logic [ST_W-1:0] BS_RESERVED = 2'd3;

    localparam logic STATUS_OK        = 1'b0;
    localparam logic STATUS_PARAM_ERR = 1'b1;
    localparam logic KIND_DONE        = 1'b0;
    localparam logic KIND_ERASE       = 1'b1;

    localparam logic CFG_FLASH_BLOCKS = 1'b0;
    localparam logic CFG_ERASE_SHIFT  = 1'b1;

    typedef enum logic [1:0] {
        WS_CLEAR,
        WS_IDLE,
        WS_WALK,
        WS_FLUSH
    } walk_state_t;

    typedef struct packed {
        logic             status;
        logic             kind;
        logic             found;
        logic [IDX_W-1:0] block_index;
        logic [CNT_W-1:0] run_length;
        logic             last;
    } res_t;

    typedef struct packed {
        logic [POS_W-1:0]   fb;
        logic [SHIFT_W-1:0] erase_shift;
    } cfg_t;

    typedef struct packed {
        logic rd_en;
        logic wr_en;
    } mem_ctl_t;

endpackage

// File: design/flash_block_state_map_top.sv
// Top level of the flash block state map: configuration registers and
// the walker, memory and output register. Uses fbsm_pkg.
//
// Usage. A request (mode, start_block, block_count, mark_value) is taken on the
// in_valid/in_ready handshake; results leave on out_valid/out_ready, one
// result per handshake, and the final result of a request carries last = 1.
// Mark, search, query and erase scan walk the map one entry per cycle, save for
// the pauses of an erase scan noted below, through the single read port of the
// state memory, whose read data is registered. The last result enters the output
// register once the walk ends (an erase scan that ends holding two runs hands over
// both), and in_ready returns once it is handed over; a search or query that
// decides early stops there. Requests rejected at decode or with an empty range
// go straight to their result. An erase scan emits one erase command per merged
// run; a run is held back until the next one closes so the last command can be
// flagged. Clear sweeps all MAP_BLOCKS entries, one per cycle, setting each entry
// dirty, then completes. One request is handled at a time. Reset: the same
// sweep runs and sets every entry dirty; no request is taken until it ends.
// Configuration writes must only happen while the block is idle. When the
// receiver stalls, the result waits in the output register; an erase scan that
// must hand over another run pauses its walk until the register frees up.
module flash_block_state_map_top
    import fbsm_pkg::*;
#(
    parameter int unsigned MAP_BLOCKS = MAP_BLOCKS_DEF
)
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              cfg_we,
    input  logic              cfg_index,
    input  logic [CNT_W-1:0]  cfg_wdata,
    input  logic              in_valid,
    output logic              in_ready,
    input  logic [MODE_W-1:0] mode,
    input  logic [IDX_W-1:0]  start_block,
    input  logic [CNT_W-1:0]  block_count,
    input  logic [ST_W-1:0]   mark_value,
    output logic              out_valid,
    input  logic              out_ready,
    output logic              status,
    output logic              kind,
    output logic              found,
    output logic [IDX_W-1:0]  block_index,
    output logic [CNT_W-1:0]  run_length,
    output logic              last
);

    localparam int unsigned AW = $clog2(MAP_BLOCKS);

    logic [CNT_W-1:0]   flash_blocks_reg;
    logic [CNT_W-1:0]   flash_blocks_next;
    logic [SHIFT_W-1:0] erase_shift_reg;
    logic [SHIFT_W-1:0] erase_shift_next;

    cfg_t            cfg;
    mem_ctl_t        mem_ctl;
    logic [AW-1:0]   mem_raddr;
    logic [AW-1:0]   mem_waddr;
    logic [ST_W-1:0] mem_wdata;
    logic [ST_W-1:0] mem_rdata;
    logic            push_valid;
    logic            push_ready;
    res_t            push_data;

    // Register writes; the index is one bit wide, so every write hits a register.
    always_comb
    begin
        flash_blocks_next = flash_blocks_reg;
        erase_shift_next  = erase_shift_reg;
        if (cfg_we)
        begin
            unique case (cfg_index)
                CFG_FLASH_BLOCKS: flash_blocks_next = cfg_wdata;
                CFG_ERASE_SHIFT:  erase_shift_next  = cfg_wdata[SHIFT_W-1:0];
                default:          flash_blocks_next = flash_blocks_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            flash_blocks_reg <= CNT_W'(16384);
            erase_shift_reg  <= SHIFT_W'(4);
        end
        else
        begin
            flash_blocks_reg <= flash_blocks_next;
            erase_shift_reg  <= erase_shift_next;
        end
    end

    // A flash size beyond the map acts as the map size.
    assign cfg.fb = (32'(flash_blocks_reg) > MAP_BLOCKS) ? POS_W'(MAP_BLOCKS)
                                                         : POS_W'(flash_blocks_reg);
    assign cfg.erase_shift = erase_shift_reg;

    fbsm_walker #(
        .MAP_BLOCKS (MAP_BLOCKS)
    ) u_walker (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_ready    (in_ready),
        .mode        (mode),
        .start_block (start_block),
        .block_count (block_count),
        .mark_value  (mark_value),
        .cfg         (cfg),
        .mem_ctl     (mem_ctl),
        .mem_raddr   (mem_raddr),
        .mem_waddr   (mem_waddr),
        .mem_wdata   (mem_wdata),
        .mem_rdata   (mem_rdata),
        .push_valid  (push_valid),
        .push_ready  (push_ready),
        .push_data   (push_data)
    );

    fbsm_map_ram #(
        .DEPTH (MAP_BLOCKS)
    ) u_map_ram (
        .clk   (clk),
        .ctl   (mem_ctl),
        .raddr (mem_raddr),
        .waddr (mem_waddr),
        .wdata (mem_wdata),
        .rdata (mem_rdata)
    );

    fbsm_out_stage u_out_stage (
        .clk         (clk),
        .rst_n       (rst_n),
        .push_valid  (push_valid),
        .push_data   (push_data),
        .push_ready  (push_ready),
        .out_valid   (out_valid),
        .out_ready   (out_ready),
        .status      (status),
        .kind        (kind),
        .found       (found),
        .block_index (block_index),
        .run_length  (run_length),
        .last        (last)
    );

endmodule

// File: design/fbsm_map_ram.sv
// Block state memory: two bits per map block, one write and one read port.
// Read data is registered and held while the read enable is low; uses fbsm_pkg.
module fbsm_map_ram
    import fbsm_pkg::*;
#(
    parameter int unsigned DEPTH = MAP_BLOCKS_DEF
)
(
    input  logic                     clk,
    input  mem_ctl_t                 ctl,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [ST_W-1:0]          wdata,
    output logic [ST_W-1:0]          rdata
);

    logic [ST_W-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (ctl.wr_en)
        begin
            mem[waddr] <= wdata;
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctl.rd_en)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

// File: design/fbsm_out_stage.sv
// Output register of the result channel, so the walker can move on
// while a result waits for the receiver. Uses fbsm_pkg.
module fbsm_out_stage
    import fbsm_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             push_valid,
    input  res_t             push_data,
    output logic             push_ready,
    output logic             out_valid,
    input  logic             out_ready,
    output logic             status,
    output logic             kind,
    output logic             found,
    output logic [IDX_W-1:0] block_index,
    output logic [CNT_W-1:0] run_length,
    output logic             last
);

    logic out_valid_reg;
    logic out_valid_next;
    res_t res_reg;

    assign push_ready = !out_valid_reg || out_ready;

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (push_ready)
        begin
            out_valid_next = push_valid;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push_valid && push_ready)
        begin
            res_reg <= push_data;
        end
    end

    assign out_valid   = out_valid_reg;
    assign status      = res_reg.status;
    assign kind        = res_reg.kind;
    assign found       = res_reg.found;
    assign block_index = res_reg.block_index;
    assign run_length  = res_reg.run_length;
    assign last        = res_reg.last;

endmodule

// File: design/fbsm_walker.sv
// Request decoder and map walker: checks a request, then walks the map one entry per cycle
// unless stalled, writing back marks and erases. Uses fbsm_pkg and the defines header.
`include "flash_block_state_map_top_defines.svh"

module fbsm_walker
    import fbsm_pkg::*;
#(
    parameter int unsigned MAP_BLOCKS = MAP_BLOCKS_DEF
)
(
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          in_valid,
    output logic                          in_ready,
    input  logic [MODE_W-1:0]             mode,
    input  logic [IDX_W-1:0]              start_block,
    input  logic [CNT_W-1:0]              block_count,
    input  logic [ST_W-1:0]               mark_value,
    input  cfg_t                          cfg,
    output mem_ctl_t                      mem_ctl,
    output logic [$clog2(MAP_BLOCKS)-1:0] mem_raddr,
    output logic [$clog2(MAP_BLOCKS)-1:0] mem_waddr,
    output logic [ST_W-1:0]               mem_wdata,
    input  logic [ST_W-1:0]               mem_rdata,
    output logic                          push_valid,
    input  logic                          push_ready,
    output res_t                          push_data
);

    localparam int unsigned AW = $clog2(MAP_BLOCKS);
    localparam logic [AW-1:0] CLR_LAST = AW'(MAP_BLOCKS - 1);

    walk_state_t state_reg, state_next;

    // Control state.
    logic             issue_reg, issue_next;
    logic             rd_valid_reg, rd_valid_next;
    logic             pend_valid_reg, pend_valid_next;
    logic             blk_bad_reg, blk_bad_next;
    logic [CNT_W-1:0] run_len_reg, run_len_next;
    logic [AW-1:0]    clr_reg, clr_next;
    logic             clr_lock_reg, clr_lock_next;

    // Request payload and walk positions.
    logic [MODE_W-1:0] mode_reg, mode_next;
    logic [ST_W-1:0]   val_reg, val_next;
    logic [POS_W-1:0]  pos_reg, pos_next;
    logic [POS_W-1:0]  end_reg, end_next;
    logic [POS_W-1:0]  rd_pos_reg, rd_pos_next;
    logic              rd_last_reg, rd_last_next;
    logic [IDX_W-1:0]  run_start_reg, run_start_next;
    logic [IDX_W-1:0]  pend_start_reg, pend_start_next;
    logic [CNT_W-1:0]  pend_len_reg, pend_len_next;
    res_t              res_reg, res_next;

    // Request decode.
    logic [POS_W-1:0] sum;
    logic             range_bad;
    logic             erase_bad;
    logic             dec_walk;
    logic             dec_clear;
    logic [POS_W-1:0] dec_end;
    res_t             dec_res;

    // Erase block geometry.
    logic [7:0] esz;
    logic [6:0] mask;

    // Walk control.
    logic       acc;
    logic       blk_end;
    logic       blk_bad_now;
    logic       run_close;
    logic       stall;
    logic       b_act;
    logic       hit;
    logic       walk_end;
    logic       flush_done;
    logic [POS_W-1:0] pos_inc;

    assign esz  = 8'd1 << cfg.erase_shift;
    assign mask = 7'(esz - 8'd1);

    assign in_ready    = (state_reg == WS_IDLE);
    assign acc         = in_valid && in_ready;
    assign pos_inc     = pos_reg + POS_W'(1);
    assign blk_end     = ((rd_pos_reg[6:0] & mask) == mask);
    assign blk_bad_now = blk_bad_reg || (mem_rdata != BS_ERASED);
    assign run_close   = (mode_reg == MODE_ERASE) && blk_end && !blk_bad_now
                         && (run_len_reg != '0);
    // A closing run must hand the previous run to the output register first.
    assign stall       = (state_reg == WS_WALK) && rd_valid_reg && run_close
                         && pend_valid_reg && !push_ready;
    assign b_act       = (state_reg == WS_WALK) && rd_valid_reg && !stall;
    assign hit         = b_act && (((mode_reg == MODE_SEARCH) && (mem_rdata == val_reg))
                         || ((mode_reg == MODE_QUERY) && (mem_rdata != BS_ERASED)));
    assign walk_end    = b_act && (hit || rd_last_reg);
    assign flush_done  = push_ready && !(pend_valid_reg && (run_len_reg != '0));

    always_comb
    begin
        sum       = POS_W'(start_block) + POS_W'(block_count);
        range_bad = (sum > cfg.fb);
        erase_bad = range_bad || ((start_block[6:0] & mask) != '0)
                    || ((block_count[6:0] & mask) != '0)
                    || ((block_count >> cfg.erase_shift) > CNT_W'(MAX_ERASE_SPAN));
        dec_res        = '0;
        dec_res.status = STATUS_OK;
        dec_res.kind   = KIND_DONE;
        dec_res.last   = 1'b1;
        dec_walk  = 1'b0;
        dec_clear = 1'b0;
        dec_end   = sum;
        unique case (mode)
            MODE_MARK:
            begin
                if (range_bad || (mark_value == BS_RESERVED))
                begin
                    dec_res.status = STATUS_PARAM_ERR;
                end
                else
                begin
                    dec_walk = (block_count != '0);
                end
            end
            MODE_CLEAR:
            begin
                dec_clear = 1'b1;
            end
            MODE_ERASE:
            begin
                if (erase_bad)
                begin
                    dec_res.status = STATUS_PARAM_ERR;
                end
                else
                begin
                    dec_walk = (block_count != '0);
                end
            end
            MODE_SEARCH:
            begin
                // An empty or out-of-range search is simply not found.
                if ((block_count != '0) && (POS_W'(start_block) < cfg.fb))
                begin
                    dec_walk = 1'b1;
                    dec_end  = range_bad ? cfg.fb : sum;
                end
            end
            MODE_QUERY:
            begin
                if (range_bad)
                begin
                    dec_res.status = STATUS_PARAM_ERR;
                end
                else
                begin
                    // Found until a block that is not erased shows up.
                    dec_res.found = 1'b1;
                    dec_walk      = (block_count != '0);
                end
            end
            default:
            begin
                dec_res.status = STATUS_PARAM_ERR;
            end
        endcase
    end

    // Next state.
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            WS_CLEAR:
            begin
                if (clr_reg == CLR_LAST)
                begin
                    state_next = clr_lock_reg ? WS_FLUSH : WS_IDLE;
                end
            end
            WS_IDLE:
            begin
                if (acc)
                begin
                    if (dec_clear)
                    begin
                        state_next = WS_CLEAR;
                    end
                    else if (dec_walk)
                    begin
                        state_next = WS_WALK;
                    end
                    else
                    begin
                        state_next = WS_FLUSH;
                    end
                end
            end
            WS_WALK:
            begin
                if (walk_end)
                begin
                    state_next = WS_FLUSH;
                end
            end
            WS_FLUSH:
            begin
                if (flush_done)
                begin
                    state_next = WS_IDLE;
                end
            end
            default:
            begin
                state_next = WS_IDLE;
            end
        endcase
    end

    // Datapath and outputs.
    always_comb
    begin
        issue_next      = issue_reg;
        rd_valid_next   = rd_valid_reg;
        pend_valid_next = pend_valid_reg;
        blk_bad_next    = blk_bad_reg;
        run_len_next    = run_len_reg;
        clr_next        = clr_reg;
        clr_lock_next   = clr_lock_reg;
        mode_next       = mode_reg;
        val_next        = val_reg;
        pos_next        = pos_reg;
        end_next        = end_reg;
        rd_pos_next     = rd_pos_reg;
        rd_last_next    = rd_last_reg;
        run_start_next  = run_start_reg;
        pend_start_next = pend_start_reg;
        pend_len_next   = pend_len_reg;
        res_next        = res_reg;

        mem_ctl   = '0;
        mem_raddr = pos_reg[AW-1:0];
        mem_waddr = rd_pos_reg[AW-1:0];
        mem_wdata = val_reg;

        push_valid            = 1'b0;
        push_data             = res_reg;

        unique case (state_reg)
            WS_CLEAR:
            begin
                mem_ctl.wr_en = 1'b1;
                mem_waddr     = clr_reg;
                mem_wdata     = BS_DIRTY;
                clr_next      = clr_reg + AW'(1);
                if (clr_reg == CLR_LAST)
                begin
                    clr_lock_next = 1'b0;
                end
            end
            WS_IDLE:
            begin
                if (acc)
                begin
                    mode_next       = mode;
                    val_next        = mark_value;
                    pos_next        = POS_W'(start_block);
                    end_next        = dec_end;
                    res_next        = dec_res;
                    issue_next      = dec_walk;
                    rd_valid_next   = 1'b0;
                    blk_bad_next    = 1'b0;
                    run_len_next    = '0;
                    pend_valid_next = 1'b0;
                    clr_next        = '0;
                    clr_lock_next   = dec_clear;
                end
            end
            WS_WALK:
            begin
                if (!stall)
                begin
                    // Read stage: fetch the next entry of the range.
                    if (issue_reg)
                    begin
                        mem_ctl.rd_en = 1'b1;
                        pos_next      = pos_inc;
                        rd_valid_next = 1'b1;
                        rd_pos_next   = pos_reg;
                        rd_last_next  = (pos_inc == end_reg);
                        issue_next    = (pos_inc != end_reg);
                    end
                    else
                    begin
                        rd_valid_next = 1'b0;
                    end

                    // Modify and write-back stage on the entry just read.
                    if (rd_valid_reg)
                    begin
                        case (mode_reg)
                            MODE_MARK:
                            begin
                                // Dirty and erased leave locked blocks alone.
                                mem_ctl.wr_en = (val_reg == BS_LOCKED)
                                                || (mem_rdata != BS_LOCKED);
                                mem_wdata     = val_reg;
                            end
                            MODE_ERASE:
                            begin
                                // Erasing a block that is already fully erased
                                // changes nothing, so every entry that is not locked is written here.
                                mem_ctl.wr_en = (mem_rdata != BS_LOCKED);
                                mem_wdata     = BS_ERASED;
                                if (blk_end)
                                begin
                                    blk_bad_next = 1'b0;
                                    if (blk_bad_now)
                                    begin
                                        if (run_len_reg == '0)
                                        begin
                                            run_start_next = rd_pos_reg[IDX_W-1:0]
                                                             & ~IDX_W'(mask);
                                        end
                                        run_len_next = run_len_reg + CNT_W'(esz);
                                    end
                                    else if (run_len_reg != '0)
                                    begin
                                        push_valid             = pend_valid_reg;
                                        push_data.status       = STATUS_OK;
                                        push_data.kind         = KIND_ERASE;
                                        push_data.found        = 1'b0;
                                        push_data.block_index  = pend_start_reg;
                                        push_data.run_length   = pend_len_reg;
                                        push_data.last         = 1'b0;
                                        pend_valid_next        = 1'b1;
                                        pend_start_next        = run_start_reg;
                                        pend_len_next          = run_len_reg;
                                        run_len_next           = '0;
                                    end
                                end
                                else
                                begin
                                    blk_bad_next = blk_bad_now;
                                end
                            end
                            MODE_SEARCH:
                            begin
                                if (mem_rdata == val_reg)
                                begin
                                    res_next.found       = 1'b1;
                                    res_next.block_index = rd_pos_reg[IDX_W-1:0];
                                end
                            end
                            MODE_QUERY:
                            begin
                                if (mem_rdata != BS_ERASED)
                                begin
                                    res_next.found = 1'b0;
                                end
                            end
                            default:
                            begin
                            end
                        endcase
                        if (walk_end)
                        begin
                            rd_valid_next = 1'b0;
                            issue_next    = 1'b0;
                        end
                    end
                end
            end
            WS_FLUSH:
            begin
                push_valid = 1'b1;
                if (pend_valid_reg)
                begin
                    push_data.status      = STATUS_OK;
                    push_data.kind        = KIND_ERASE;
                    push_data.found       = 1'b0;
                    push_data.block_index = pend_start_reg;
                    push_data.run_length  = pend_len_reg;
                    push_data.last        = (run_len_reg == '0);
                    if (push_ready)
                    begin
                        pend_valid_next = 1'b0;
                    end
                end
                else if (run_len_reg != '0)
                begin
                    push_data.status      = STATUS_OK;
                    push_data.kind        = KIND_ERASE;
                    push_data.found       = 1'b0;
                    push_data.block_index = run_start_reg;
                    push_data.run_length  = run_len_reg;
                    push_data.last        = 1'b1;
                    if (push_ready)
                    begin
                        run_len_next = '0;
                    end
                end
            end
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= WS_CLEAR;
            issue_reg      <= 1'b0;
            rd_valid_reg   <= 1'b0;
            pend_valid_reg <= 1'b0;
            blk_bad_reg    <= 1'b0;
            run_len_reg    <= '0;
            clr_reg        <= '0;
            clr_lock_reg   <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            issue_reg      <= issue_next;
            rd_valid_reg   <= rd_valid_next;
            pend_valid_reg <= pend_valid_next;
            blk_bad_reg    <= blk_bad_next;
            run_len_reg    <= run_len_next;
            clr_reg        <= clr_next;
            clr_lock_reg   <= clr_lock_next;
        end
    end

    always_ff @(posedge clk)
    begin
        mode_reg       <= mode_next;
        val_reg        <= val_next;
        pos_reg        <= pos_next;
        end_reg        <= end_next;
        rd_pos_reg     <= rd_pos_next;
        rd_last_reg    <= rd_last_next;
        run_start_reg  <= run_start_next;
        pend_start_reg <= pend_start_next;
        pend_len_reg   <= pend_len_next;
        res_reg        <= res_next;
    end

    `FBSM_ASSERT_NOW(a_no_write_idle, state_reg == WS_IDLE, !mem_ctl.wr_en, "map written while idle")
    `FBSM_ASSERT_NOW(a_stall_freezes_memory, stall, !mem_ctl.rd_en && !mem_ctl.wr_en, "memory accessed during a stall")
    `FBSM_ASSERT_NOW(a_pend_only_erase, pend_valid_reg, mode_reg == MODE_ERASE, "pending run outside an erase scan")
    `FBSM_ASSERT_NEXT(a_hit_ends_walk, hit, state_reg == WS_FLUSH && !rd_valid_reg, "walk kept going after a hit")

endmodule

// File: sim/testbench.sv
// Self-checking testbench for flash_block_state_map_top.
// Needs fbsm_pkg and the top level. Requests are checked against a state map
// held in the testbench and updated in the order the block accepts them.
module testbench;
    import fbsm_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    // Illegal operation codes that the block must reject.
    localparam logic [MODE_W-1:0] MODE_BAD_LO = 3'd5;
    localparam logic [MODE_W-1:0] MODE_BAD_HI = 3'd7;

    // An erase scan reports at most this many runs.
    localparam int unsigned MAX_ERASE_CMDS = 64;

    // The receiver holds off once for a long stretch after this many requests
    // have gone in, so the block backs up and drops in_ready.
    localparam int unsigned HOLD_AFTER = 130;
    localparam int unsigned LONG_HOLD  = 400;

    typedef struct packed {
        logic [MODE_W-1:0] op;
        logic [IDX_W-1:0]  first;
        logic [CNT_W-1:0]  count;
        logic [ST_W-1:0]   value;
    } flash_request_t;

    logic              clk;
    logic              rst_n       = 1'b0;
    logic              cfg_we      = 1'b0;
    logic              cfg_index   = CFG_FLASH_BLOCKS;
    logic [CNT_W-1:0]  cfg_wdata   = '0;
    logic              in_valid    = 1'b0;
    logic              in_ready;
    logic [MODE_W-1:0] mode        = MODE_MARK;
    logic [IDX_W-1:0]  start_block = '0;
    logic [CNT_W-1:0]  block_count = '0;
    logic [ST_W-1:0]   mark_value  = BS_DIRTY;
    logic              out_valid;
    logic              out_ready   = 1'b1;
    logic              status;
    logic              kind;
    logic              found;
    logic [IDX_W-1:0]  block_index;
    logic [CNT_W-1:0]  run_length;
    logic              last;

    // Our own copy of the block state and of its two registers.
    logic [ST_W-1:0]   flash_map [MAP_BLOCKS_DEF];
    int unsigned       cfg_flash_blocks = MAP_BLOCKS_DEF;
    int unsigned       cfg_erase_shift  = 4;

    flash_request_t    pending_requests [$];
    res_t              expected_results [$];
    flash_request_t    offered;

    int unsigned       requests_queued   = 0;
    int unsigned       requests_accepted = 0;
    int unsigned       mismatch_count    = 0;
    logic              request_taken     = 1'b0;

    // Sender burst and gap counters.
    int unsigned       burst_left = 0;
    int unsigned       gap_left   = 0;

    // Receiver stall pattern and the one long hold-off.
    logic [31:0]       ready_pattern = '1;
    int unsigned       pattern_left  = 0;
    int unsigned       hold_left     = 0;
    logic              hold_done     = 1'b0;

    // Only a handful of random requests may take a bulk span or sweep the map.
    int unsigned       bulk_left   = 6;
    int unsigned       clears_left = 3;

    flash_block_state_map_top dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_we      (cfg_we),
        .cfg_index   (cfg_index),
        .cfg_wdata   (cfg_wdata),
        .in_valid    (in_valid),
        .in_ready    (in_ready),
        .mode        (mode),
        .start_block (start_block),
        .block_count (block_count),
        .mark_value  (mark_value),
        .out_valid   (out_valid),
        .out_ready   (out_ready),
        .status      (status),
        .kind        (kind),
        .found       (found),
        .block_index (block_index),
        .run_length  (run_length),
        .last        (last)
    );

    always
    begin
        clk = 1'b0;
        #1;
        clk = 1'b1;
        #1;
    end

    // ------------------------------------------------------------------
    // Prediction
    // ------------------------------------------------------------------

    function automatic int unsigned blocks_in_use();
        return (cfg_flash_blocks > MAP_BLOCKS_DEF) ? MAP_BLOCKS_DEF : cfg_flash_blocks;
    endfunction

    function automatic res_t make_result(logic st, logic kd, logic hit,
                                         int unsigned idx, int unsigned len, logic fin);
        res_t r;
        r.status      = st;
        r.kind        = kd;
        r.found       = hit;
        r.block_index = IDX_W'(idx);
        r.run_length  = CNT_W'(len);
        r.last        = fin;
        return r;
    endfunction

    // Dirty and erased leave locked blocks alone; locked overwrites anything.
    function automatic void mark_range(int unsigned from, int unsigned to, logic [ST_W-1:0] value);
        for (int unsigned i = from; i < to && i < MAP_BLOCKS_DEF; i++)
        begin
            if (value == BS_LOCKED || flash_map[i] != BS_LOCKED)
                flash_map[i] = value;
        end
    endfunction

    function automatic bit all_erased(int unsigned from, int unsigned to);
        for (int unsigned i = from; i < to && i < MAP_BLOCKS_DEF; i++)
        begin
            if (flash_map[i] != BS_ERASED)
                return 1'b0;
        end
        return 1'b1;
    endfunction

    // Applies one accepted request to the map and queues the results it
    // must produce, in order.
    function automatic void predict_request(flash_request_t req);
        int unsigned fb;
        int unsigned stop;
        int unsigned esz;
        int unsigned run_start;
        int unsigned run_len;
        res_t        erase_cmds [$];
        res_t        done;
        fb        = blocks_in_use();
        stop      = req.first + req.count;
        run_start = 0;
        run_len   = 0;
        done      = make_result(STATUS_OK, KIND_DONE, 1'b0, 0, 0, 1'b1);
        case (req.op)
            MODE_MARK:
            begin
                if (stop > fb || req.value == BS_RESERVED)
                    done.status = STATUS_PARAM_ERR;
                else
                    mark_range(req.first, stop, req.value);
            end
            MODE_CLEAR:
            begin
                foreach (flash_map[i])
                    flash_map[i] = BS_DIRTY;
            end
            MODE_ERASE:
            begin
                esz = 1 << cfg_erase_shift;
                if (stop > fb || (req.first & (esz - 1)) != 0 || (req.count & (esz - 1)) != 0
                    || (req.count >> cfg_erase_shift) > MAX_ERASE_SPAN)
                begin
                    done.status = STATUS_PARAM_ERR;
                end
                else
                begin
                    // The pass at i == stop closes a run still open at the end.
                    for (int unsigned i = req.first; i <= stop; i += esz)
                    begin
                        if (i < stop && !all_erased(i, i + esz))
                        begin
                            if (run_len == 0)
                                run_start = i;
                            run_len += esz;
                        end
                        else if (run_len != 0)
                        begin
                            if (erase_cmds.size() < MAX_ERASE_CMDS)
                                erase_cmds.push_back(make_result(STATUS_OK, KIND_ERASE, 1'b0,
                                                                 run_start, run_len, 1'b0));
                            mark_range(run_start, run_start + run_len, BS_ERASED);
                            run_len = 0;
                        end
                    end
                end
            end
            MODE_SEARCH:
            begin
                if (req.count != 0 && req.first < fb)
                begin
                    if (stop > fb)
                        stop = fb;
                    for (int unsigned i = req.first; i < stop; i++)
                    begin
                        if (flash_map[i] == req.value)
                        begin
                            done.found       = 1'b1;
                            done.block_index = IDX_W'(i);
                            break;
                        end
                    end
                end
            end
            MODE_QUERY:
            begin
                if (stop > fb)
                    done.status = STATUS_PARAM_ERR;
                else
                    done.found = all_erased(req.first, stop);
            end
            default:
                done.status = STATUS_PARAM_ERR;
        endcase
        if (erase_cmds.size() == 0)
        begin
            expected_results.push_back(done);
        end
        else
        begin
            erase_cmds[erase_cmds.size() - 1].last = 1'b1;
            foreach (erase_cmds[i])
                expected_results.push_back(erase_cmds[i]);
        end
    endfunction

    // ------------------------------------------------------------------
    // Checking
    // ------------------------------------------------------------------

    function automatic void check_field(string name, int unsigned want, int unsigned got);
        if (want != got)
        begin
            $display("%0t: %s expected %0d, got %0d", $realtime, name, want, got);
            mismatch_count++;
        end
    endfunction

    function automatic void compare_result();
        res_t want;
        if (expected_results.size() == 0)
        begin
            $display({"%0t: result expected none, got status %0d kind %0d found %0d",
                      " index %0d length %0d last %0d"},
                     $realtime, status, kind, found, block_index, run_length, last);
            mismatch_count++;
        end
        else
        begin
            want = expected_results.pop_front();
            check_field("status", want.status, status);
            check_field("kind", want.kind, kind);
            check_field("found", want.found, found);
            check_field("block_index", want.block_index, block_index);
            check_field("run_length", want.run_length, run_length);
            check_field("last", want.last, last);
        end
    endfunction

    // Everything is sampled on the rising edge. Results are checked before
    // the request of the same edge is predicted; a result never leaves in
    // the cycle its request goes in, so the order costs nothing.
    always @(posedge clk)
    begin
        request_taken <= rst_n && in_valid && in_ready;
        if (rst_n)
        begin
            if (out_valid && out_ready)
                compare_result();
            if (in_valid && in_ready)
            begin
                predict_request('{op: mode, first: start_block, count: block_count,
                                  value: mark_value});
                requests_accepted++;
            end
        end
    end

    // ------------------------------------------------------------------
    // Request driver: bursts of random length separated by random gaps.
    // A request stays on the port until the edge that takes it.
    // ------------------------------------------------------------------

    always @(negedge clk)
    begin
        if (!in_valid || request_taken)
        begin
            if (gap_left == 0 && pending_requests.size() != 0)
            begin
                offered = pending_requests.pop_front();
                in_valid    <= 1'b1;
                mode        <= offered.op;
                start_block <= offered.first;
                block_count <= offered.count;
                mark_value  <= offered.value;
                if (burst_left != 0)
                begin
                    burst_left--;
                end
                else
                begin
                    // A third of the bursts run straight into the next one.
                    burst_left = $urandom_range(0, 15);
                    gap_left   = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 8);
                end
            end
            else
            begin
                in_valid <= 1'b0;
                if (gap_left != 0)
                    gap_left--;
            end
        end
    end

    // ------------------------------------------------------------------
    // Result receiver: a rotating 32-bit ready pattern, reloaded once it has run out,
    // sometimes all ready. Once in the run it holds off for a long stretch
    // while the sender keeps offering requests.
    // ------------------------------------------------------------------

    always @(negedge clk)
    begin
        if (hold_left != 0)
        begin
            out_ready <= 1'b0;
            hold_left--;
        end
        else if (!hold_done && requests_accepted >= HOLD_AFTER)
        begin
            hold_done = 1'b1;
            hold_left = LONG_HOLD - 1;
            out_ready <= 1'b0;
        end
        else
        begin
            if (pattern_left == 0)
            begin
                ready_pattern = $urandom | $urandom;
                if ($urandom_range(0, 3) == 0)
                    ready_pattern = '1;
                pattern_left = 32;
            end
            out_ready <= ready_pattern[0];
            ready_pattern = {ready_pattern[0], ready_pattern[31:1]};
            pattern_left--;
        end
    end

    // ------------------------------------------------------------------
    // Stimulus
    // ------------------------------------------------------------------

    function automatic void queue_request(logic [MODE_W-1:0] op, int unsigned first,
                                          int unsigned count, logic [ST_W-1:0] value);
        pending_requests.push_back('{op: op, first: IDX_W'(first), count: CNT_W'(count),
                                     value: value});
        requests_queued++;
    endfunction

    // Builds one random request for the current register settings. Most
    // requests are legal and short and land in the first 512 blocks, so
    // marks, erase scans, searches and queries keep meeting each other's
    // work; some sit right at or just past the end of the flash, and a few
    // are illegal or carry wide random fields.
    function automatic flash_request_t random_request();
        flash_request_t req;
        int unsigned    fb;
        int unsigned    esz;
        int unsigned    window;
        int unsigned    span;
        int unsigned    first;
        int unsigned    roll;
        int unsigned    blocks;
        fb     = blocks_in_use();
        esz    = 1 << cfg_erase_shift;
        window = (fb < 512) ? fb : 512;
        roll   = $urandom_range(0, 99);
        req.value = ST_W'($urandom_range(0, 2));
        if ($urandom_range(0, 15) == 0)
            req.value = BS_RESERVED;

        span = $urandom_range(0, 40);
        if ($urandom_range(0, 4) == 0)
        begin
            span = $urandom_range(0, 600);
        end
        else if (bulk_left != 0 && $urandom_range(0, 29) == 0)
        begin
            bulk_left--;
            span = $urandom_range(0, fb);
        end

        first = $urandom_range(0, window - 1);
        case ($urandom_range(0, 9))
            0: first = (span < fb) ? fb - span : 0;                  // ends on the last block
            1: first = fb - ((span < fb) ? span : fb) + 1;           // runs one block too far
            default: ;
        endcase

        if (roll < 30)
        begin
            req.op = MODE_MARK;
        end
        else if (roll < 52)
        begin
            // Erase scans are mostly aligned and inside the flash; now and
            // then one spans more erase blocks than allowed or is misaligned.
            req.op = MODE_ERASE;
            blocks = $urandom_range(0, 6);
            if ($urandom_range(0, 19) == 0)
                blocks = $urandom_range(100, MAX_ERASE_SPAN + 4);
            span  = blocks * esz;
            first = (first >> cfg_erase_shift) << cfg_erase_shift;
            if (first + span > fb)
                first = (span <= fb) ? ((fb - span) >> cfg_erase_shift) << cfg_erase_shift : 0;
            if ($urandom_range(0, 9) == 0)
            begin
                if ($urandom_range(0, 1) == 0)
                    first++;
                else
                    span++;
            end
        end
        else if (roll < 70)
        begin
            req.op = MODE_SEARCH;
        end
        else if (roll < 88)
        begin
            req.op = MODE_QUERY;
        end
        else if (roll < 91 && clears_left != 0)
        begin
            clears_left--;
            req.op = MODE_CLEAR;
        end
        else if (roll < 94)
        begin
            req.op = MODE_W'($urandom_range(MODE_BAD_LO, MODE_BAD_HI));
        end
        else
        begin
            req.op    = ($urandom_range(0, 1) == 0) ? MODE_MARK : MODE_QUERY;
            req.value = ST_W'($urandom_range(0, 3));
            first     = $urandom_range(0, MAP_BLOCKS_DEF - 1);
            span      = $urandom_range(0, MAP_BLOCKS_DEF);
        end

        if (first > MAP_BLOCKS_DEF - 1)
            first = MAP_BLOCKS_DEF - 1;
        req.first = IDX_W'(first);
        req.count = CNT_W'(span);
        return req;
    endfunction

    task automatic queue_random_requests(int unsigned n);
        flash_request_t req;
        @(posedge clk);
        repeat (n)
        begin
            req = random_request();
            queue_request(req.op, req.first, req.count, req.value);
        end
    endtask

    task automatic write_register(logic which, int unsigned value);
        @(negedge clk);
        cfg_we    <= 1'b1;
        cfg_index <= which;
        cfg_wdata <= CNT_W'(value);
        @(negedge clk);
        cfg_we <= 1'b0;
        if (which == CFG_FLASH_BLOCKS)
            cfg_flash_blocks = value & 32'h7FFF;
        else
            cfg_erase_shift = value & 32'h7;
    endtask

    // Waits until every queued request has gone in and every result has
    // come back, then until the block shows ready again, then settles.
    task automatic wait_until_drained(int unsigned settle);
        do
            @(negedge clk);
        while (requests_accepted != requests_queued || expected_results.size() != 0);
        while (!in_ready)
            @(negedge clk);
        repeat (settle)
            @(negedge clk);
    endtask

    initial
    begin
        foreach (flash_map[i])
            flash_map[i] = BS_DIRTY;
        rst_n = 1'b0;
        repeat (6)
            @(negedge clk);
        rst_n = 1'b1;
        @(posedge clk);

        // Directed part with the reset settings: 16384 blocks, erase blocks
        // of 16. The block is still sweeping its map after reset, so the
        // first request waits for in_ready.
        queue_request(MODE_QUERY, 0, MAP_BLOCKS_DEF, BS_DIRTY);      // whole map, all dirty
        queue_request(MODE_MARK, 16, 32, BS_ERASED);
        queue_request(MODE_MARK, 20, 2, BS_LOCKED);
        queue_request(MODE_MARK, 16, 8, BS_DIRTY);                   // must skip the locks
        queue_request(MODE_SEARCH, 0, 100, BS_LOCKED);
        queue_request(MODE_QUERY, 24, 24, BS_DIRTY);                 // fully erased range
        queue_request(MODE_QUERY, 16, 0, BS_DIRTY);                  // empty query is found
        queue_request(MODE_MARK, 40, 4, BS_RESERVED);                // unknown state
        queue_request(MODE_MARK, MAP_BLOCKS_DEF - 1, 2, BS_DIRTY);   // past the end
        queue_request(MODE_MARK, 100, 0, BS_ERASED);                 // empty mark
        queue_request(MODE_ERASE, 0, 64, BS_DIRTY);                  // two runs
        queue_request(MODE_ERASE, 8, 16, BS_DIRTY);                  // misaligned start
        queue_request(MODE_ERASE, 0, 16 * (MAX_ERASE_SPAN + 1), BS_DIRTY); // too long
        queue_request(MODE_ERASE, 32, 16, BS_DIRTY);                 // nothing to erase
        queue_request(MODE_ERASE, 0, 0, BS_DIRTY);                   // empty scan
        queue_request(MODE_ERASE, MAP_BLOCKS_DEF - 16, 32, BS_DIRTY); // past the end
        queue_request(MODE_SEARCH, MAP_BLOCKS_DEF - 1, 1, BS_RESERVED);
        queue_request(MODE_SEARCH, 5, 0, BS_DIRTY);                  // empty search
        queue_request(MODE_SEARCH, 12000, MAP_BLOCKS_DEF, BS_DIRTY); // cut at the end
        queue_request(MODE_MARK, 0, MAP_BLOCKS_DEF, BS_LOCKED);      // lock everything
        queue_request(MODE_ERASE, 0, 32, BS_DIRTY);                  // locked run stays locked
        queue_request(MODE_CLEAR, 0, 0, BS_DIRTY);
        queue_request(MODE_SEARCH, 0, 64, BS_LOCKED);                // no locks left
        queue_request(MODE_BAD_LO, 3, 9, BS_ERASED);
        queue_request(MODE_BAD_HI, 0, 1, BS_LOCKED);
        queue_request(MODE_QUERY, 16000, 1000, BS_DIRTY);            // past the end
        wait_until_drained(8);

        // Full flash, single-block erase units.
        write_register(CFG_FLASH_BLOCKS, MAP_BLOCKS_DEF);
        write_register(CFG_ERASE_SHIFT, 0);
        queue_random_requests(40);
        wait_until_drained(8);

        // A flash of one block: nearly everything is out of range.
        write_register(CFG_FLASH_BLOCKS, 1);
        write_register(CFG_ERASE_SHIFT, 3);
        queue_random_requests(15);
        wait_until_drained(8);

        // Erase blocks of 64 on a flash that is not a multiple of them.
        write_register(CFG_FLASH_BLOCKS, 3000);
        write_register(CFG_ERASE_SHIFT, 6);
        queue_random_requests(40);
        wait_until_drained(8);

        // Full flash again; the long receiver hold-off falls in here.
        write_register(CFG_FLASH_BLOCKS, MAP_BLOCKS_DEF);
        write_register(CFG_ERASE_SHIFT, 2);
        queue_random_requests(40);
        wait_until_drained(20);

        if (mismatch_count == 0)
            $display("testbench: clean");
        else
            $display("testbench: errors");
        $finish;
    end

    // Watchdog. A correct run is made of the reset sweep, a few clear sweeps, a
    // few whole-map walks, and the short requests with their stalls; the limit
    // below leaves ample room for all of it.
    initial
    begin
        #2000000;
        $display("testbench: errors");
        $finish;
    end

endmodule

// File: files.f
+incdir+design
design/fbsm_pkg.sv
design/fbsm_map_ram.sv
design/fbsm_out_stage.sv
design/fbsm_walker.sv
design/flash_block_state_map_top.sv
sim/testbench.sv
